// ===== src/sm4_cbc_cipher_top_macros.svh =====
// ----------------------------------------------------------------------------
// SM4 CBC cipher assertion macros
// Shared property forms for the port-level checker of the SM4 CBC cipher.
// ----------------------------------------------------------------------------
`ifndef SM4_CBC_CIPHER_TOP_MACROS_SVH
`define SM4_CBC_CIPHER_TOP_MACROS_SVH

// Consequent checked at the same clock edge as the antecedent.
`define SM4CBC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked at the clock edge after the antecedent.
`define SM4CBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sm4cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// SM4 CBC package
// Transaction types, register indexes, cipher constants and the S-box and
// linear transform functions shared by the SM4 CBC cipher modules.
// ----------------------------------------------------------------------------
package sm4cbc_pkg;

	localparam int NUM_ROUNDS = 32;
	localparam int RND_W      = $clog2(NUM_ROUNDS);

	typedef logic [RND_W-1:0]  rnd_idx_t;
	typedef logic [3:0][31:0]  words_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_KEY_HIGH = 3'd0;
	localparam logic [2:0] REG_KEY_LOW  = 3'd1;
	localparam logic [2:0] REG_IV_HIGH  = 3'd2;
	localparam logic [2:0] REG_IV_LOW   = 3'd3;
	localparam logic [2:0] REG_MODE     = 3'd4;

	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
		logic        start_of_message;
	} blk_item_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} res_item_t;

	// Control and operands handed to the shared round unit.
	typedef struct packed {
		logic        key_sched;
		logic [31:0] rk;
		words_t      w;
	} rnd_ctrl_t;

	localparam words_t FK = '{32'hb27022dc, 32'h677d9197, 32'h56aa3350, 32'ha3b1bac6};

	localparam logic [7:0] SBOX [256] = '{
		8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
		8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
		8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
		8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
		8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
		8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
		8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
		8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
		8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
		8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
		8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
		8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
		8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
		8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
		8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
		8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
		8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
		8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
		8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
		8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
		8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
		8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
		8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
		8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
		8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
		8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
		8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
		8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
		8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
		8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
		8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
		8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
	};

	// Key schedule constant: byte j of word i is (4*i + j) * 7 modulo 256.
	function automatic logic [31:0] ck_word(input rnd_idx_t idx);
		logic [31:0] w;
		logic [9:0]  prod;
		w = '0;
		for (int j = 0; j < 4; j++) begin
			prod = {1'b0, idx, 2'(j)} * 10'd7;
			w[31-8*j -: 8] = prod[7:0];
		end
		return w;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] v);
		return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

	// Data path transform L: rotations by 2, 10, 18 and 24.
	function automatic logic [31:0] lin_data(input logic [31:0] b);
		return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^
			{b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
	endfunction

	// Key schedule transform L': rotations by 13 and 23.
	function automatic logic [31:0] lin_key(input logic [31:0] b);
		return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
	endfunction

endpackage

// ===== src/sm4cbc_round.sv =====
// ----------------------------------------------------------------------------
// SM4 CBC round unit
// One SM4 round, shared by the key schedule and the cipher rounds.
// ----------------------------------------------------------------------------
module sm4cbc_round (
	input  sm4cbc_pkg::rnd_ctrl_t ctrl,
	output logic [31:0]           new_word
);
	import sm4cbc_pkg::*;

	logic [31:0] mix;
	logic [31:0] sub;

	always_comb begin
		mix = ctrl.w[1] ^ ctrl.w[2] ^ ctrl.w[3] ^ ctrl.rk;
		sub = sub_word(mix);
		if (ctrl.key_sched) begin
			new_word = ctrl.w[0] ^ lin_key(sub);
		end else begin
			new_word = ctrl.w[0] ^ lin_data(sub);
		end
	end

endmodule

// ===== src/sm4cbc_rk_mem.sv =====
// ----------------------------------------------------------------------------
// SM4 CBC round key store
// Single-port-write, registered-read memory that holds the 32 round keys.
// ----------------------------------------------------------------------------
module sm4cbc_rk_mem (
	input  logic                 clk,
	input  logic                 wr,
	input  sm4cbc_pkg::rnd_idx_t waddr,
	input  logic [31:0]          wdata,
	input  sm4cbc_pkg::rnd_idx_t raddr,
	output logic [31:0]          rdata
);
	import sm4cbc_pkg::*;

	logic [31:0] mem [NUM_ROUNDS];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/sm4_cbc_cipher_top.sv =====
// ----------------------------------------------------------------------------
// SM4 CBC cipher
// Encrypts or decrypts 128-bit blocks with SM4 in CBC mode, one round a cycle.
// ----------------------------------------------------------------------------
// Usage:
// A block transaction enters on blk_valid/blk_stall and its result leaves on
// res_valid/res_stall; a transaction completes on an edge where valid is high
// and stall is low. The write port (wr_en, wr_index, wr_data) sets the key,
// the IV and the mode, and is to be written only while the block is idle;
// the block itself does not enforce this. No new block is accepted until the
// previous one has left the final state. The single shared round unit does
// one round per cycle. After a key write the first block first runs the key
// schedule on the same unit.
// The result sits in an output register, so a new block is accepted while a
// stalled result still waits; a finished block whose result cannot be loaded
// holds in the final state until the receiver takes the previous one.
// Reset clears the key, IV, mode and chaining value to zero and marks the
// round keys as stale, so the first block always runs the key schedule.
// ----------------------------------------------------------------------------
module sm4_cbc_cipher_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  blk_valid,
	output logic                  blk_stall,
	input  sm4cbc_pkg::blk_item_t blk_data,
	output logic                  res_valid,
	input  logic                  res_stall,
	output sm4cbc_pkg::res_item_t res_data,
	input  logic                  wr_en,
	input  logic [2:0]            wr_index,
	input  logic [63:0]           wr_data
);
	import sm4cbc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_KEXP  = 5'b00010,
		ST_PREP  = 5'b00100,
		ST_ROUND = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	localparam rnd_idx_t LAST_ROUND = RND_W'(NUM_ROUNDS - 1);

	state_t       state_q;
	rnd_idx_t     cnt_q;
	logic         keys_ready_q;
	logic         mode_q;
	logic         dec_q;
	logic [127:0] key_q;
	logic [127:0] iv_q;
	logic [127:0] chain_q;
	logic [127:0] blk_q;
	words_t       w_q;
	logic         res_valid_q;
	res_item_t    res_q;

	logic         blk_acc;
	logic         res_load;
	logic [127:0] src_blk;
	logic [127:0] cipher;
	logic [127:0] result;
	rnd_ctrl_t    rnd_ctrl;
	logic [31:0]  new_word;
	rnd_idx_t     rd_idx;
	rnd_idx_t     raddr;
	logic [31:0]  rk_rdata;

	assign blk_stall = (state_q != ST_IDLE);
	assign blk_acc   = blk_valid && !blk_stall;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// The output register can take a result when it is empty or being drained.
	assign res_load = (state_q == ST_FIN) && (!res_valid_q || !res_stall);

	// Encryption whitens the block with the chaining value before the rounds.
	assign src_blk = dec_q ? blk_q : (blk_q ^ chain_q);
	// The final four state words come out in reversed order.
	assign cipher  = {w_q[3], w_q[2], w_q[1], w_q[0]};
	assign result  = dec_q ? (cipher ^ chain_q) : cipher;

	// The round key address leads the round counter because the memory read is registered.
	// Decryption walks the keys from the top, and ~idx equals 31 - idx.
	assign rd_idx = (state_q == ST_PREP) ? '0 : cnt_q + RND_W'(1);
	assign raddr  = dec_q ? ~rd_idx : rd_idx;

	always_comb begin
		rnd_ctrl.key_sched = (state_q == ST_KEXP);
		rnd_ctrl.rk        = (state_q == ST_KEXP) ? ck_word(cnt_q) : rk_rdata;
		rnd_ctrl.w         = w_q;
	end

	sm4cbc_round u_round (
		.ctrl     (rnd_ctrl),
		.new_word (new_word)
	);

	sm4cbc_rk_mem u_rk_mem (
		.clk   (clk),
		.wr    (state_q == ST_KEXP),
		.waddr (cnt_q),
		.wdata (new_word),
		.raddr (raddr),
		.rdata (rk_rdata)
	);

	// Control, configuration and chaining state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			keys_ready_q <= 1'b0;
			mode_q       <= 1'b0;
			dec_q        <= 1'b0;
			key_q        <= '0;
			iv_q         <= '0;
			chain_q      <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_KEY_HIGH: begin
						key_q[127:64] <= wr_data;
						keys_ready_q  <= 1'b0;
					end
					REG_KEY_LOW: begin
						key_q[63:0]  <= wr_data;
						keys_ready_q <= 1'b0;
					end
					REG_IV_HIGH: iv_q[127:64] <= wr_data;
					REG_IV_LOW:  iv_q[63:0]   <= wr_data;
					REG_MODE:    mode_q       <= wr_data[0];
					default: ;
				endcase
			end

			// A newly loaded result keeps valid high; a taken one clears it.
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (blk_acc) begin
						dec_q <= mode_q;
						cnt_q <= '0;
						if (blk_data.start_of_message) begin
							chain_q <= iv_q;
						end
						state_q <= keys_ready_q ? ST_PREP : ST_KEXP;
					end
				end
				ST_KEXP: begin
					cnt_q <= cnt_q + RND_W'(1);
					if (cnt_q == LAST_ROUND) begin
						keys_ready_q <= 1'b1;
						state_q      <= ST_PREP;
					end
				end
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					cnt_q <= cnt_q + RND_W'(1);
					if (cnt_q == LAST_ROUND) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_load) begin
						// Decryption chains on the ciphertext, encryption on its output.
						chain_q <= dec_q ? blk_q : cipher;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Data path registers: the captured block, the four-word round state and
	// the output payload.
	always_ff @(posedge clk) begin
		if (blk_acc) begin
			blk_q <= {blk_data.block_high, blk_data.block_low};
			if (!keys_ready_q) begin
				w_q <= {key_q[31:0], key_q[63:32], key_q[95:64], key_q[127:96]} ^ FK;
			end
		end
		if (state_q == ST_PREP) begin
			w_q <= {src_blk[31:0], src_blk[63:32], src_blk[95:64], src_blk[127:96]};
		end
		if (state_q == ST_KEXP || state_q == ST_ROUND) begin
			w_q <= {new_word, w_q[3], w_q[2], w_q[1]};
		end
		if (res_load) begin
			res_q.result_high <= result[127:64];
			res_q.result_low  <= result[63:0];
		end
	end

endmodule

// ===== src/sm4cbc_checker.sv =====
// ----------------------------------------------------------------------------
// SM4 CBC port checker
// Watches the ports of the SM4 CBC cipher for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "sm4_cbc_cipher_top_macros.svh"

module sm4cbc_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  blk_valid,
	input logic                  blk_stall,
	input logic                  res_valid,
	input logic                  res_stall,
	input sm4cbc_pkg::res_item_t res_data
);
	import sm4cbc_pkg::*;

	// A result that is held back stays offered.
	`SM4CBC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid, "result dropped")

	// A result that is held back keeps its payload.
	`SM4CBC_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(res_data), "result moved")

	// The block is busy right after it takes a transaction.
	`SM4CBC_ASSERT_NEXT(a_busy_after_acc, blk_valid && !blk_stall, blk_stall, "not busy")

	// No result can appear in the cycle after a block is taken.
	`SM4CBC_ASSERT_NEXT(a_no_early_res, blk_valid && !blk_stall, !$rose(res_valid), "early")

endmodule

bind sm4_cbc_cipher_top sm4cbc_checker u_sm4cbc_checker (.*);
